// File: src/qpe_pkg.sv
// qpe_pkg: shared types, constants and helper functions of the
// quoted-printable encoder. No dependencies.
`timescale 1ns / 1ps

package qpe_pkg;

  // descriptor queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // configuration port
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;
  localparam logic RegSoftBreaks = 1'b0;
  localparam logic RegLineLimit  = 1'b1;
  localparam logic [6:0] LimitReset = 7'd72;

  // characters
  localparam logic [7:0] ChEq   = 8'h3D;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChMax  = 8'd126;
  localparam logic [7:0] CntMax = 8'd255;

  // output units of one request, in emission order
  typedef enum logic [1:0] {
    UNIT_PEND  = 2'd0,
    UNIT_PSOFT = 2'd1,
    UNIT_NEW   = 2'd2,
    UNIT_NSOFT = 2'd3
  } unit_t;

  typedef struct packed {
    logic [3:0] mask;    // bit per unit_t value
    logic       p_esc;
    logic [7:0] p_byte;
    logic       n_esc;
    logic [7:0] n_byte;
  } desc_t;

  typedef struct packed {
    logic       soft_breaks;
    logic [6:0] line_limit;
  } cfg_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSp) || (b == ChTab);
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    return (b == ChCr) || (b == ChLf);
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return !is_eol(b) && ((b < ChSp) || (b == ChEq) || (b > ChMax));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h37 + {4'd0, n};
    end
    return r;
  endfunction

  // saturating line count update
  function automatic logic [7:0] count_add(input logic [7:0] c, input logic [1:0] k);
    logic [8:0] s;
    s = {1'b0, c} + {7'd0, k};
    return s[8] ? CntMax : s[7:0];
  endfunction

  // lowest unit present in mask and allowed
  function automatic unit_t pick_unit(input logic [3:0] mask, input logic [3:0] allow);
    unit_t r;
    r = UNIT_PEND;
    for (int j = 3; j >= 0; j--) begin
      if (mask[j] && allow[j]) begin
        r = unit_t'(j[1:0]);
      end
    end
    return r;
  endfunction

endpackage

// File: src/qpe_stream_if.sv
// qpe_msg_if / qpe_enc_if: valid-ready channels of the encoder.
// No dependencies.
`timescale 1ns / 1ps

interface qpe_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface qpe_enc_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: src/qpe_front.sv
// qpe_front: accepts message bytes, tracks held blank and line count,
// and builds at most one output descriptor per request. Depends on qpe_pkg.
`timescale 1ns / 1ps

module qpe_front (
  input  logic                clk,
  input  logic                rst,
  input  qpe_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_message,
  output logic                push_valid,
  input  logic                push_ready,
  output qpe_pkg::desc_t      push_data
);

  logic       pend_valid;
  logic [7:0] pend_byte;
  logic [7:0] line_count;

  logic       pend_valid_next;
  logic [7:0] pend_byte_next;
  logic [7:0] line_count_next;

  logic       accept;
  logic       blank;
  logic       p_esc, p_soft;
  logic       n_en, n_esc, n_soft;
  logic [7:0] lc_p, lc_a, lc_n;
  logic [7:0] limit;

  assign limit    = {1'b0, cfg.line_limit};
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    blank  = qpe_pkg::is_blank(data_byte);
    // held blank resolved first
    p_esc  = qpe_pkg::is_eol(data_byte);
    lc_p   = pend_valid ? qpe_pkg::count_add(line_count, p_esc ? 2'd3 : 2'd1) : line_count;
    p_soft = pend_valid && cfg.soft_breaks && (lc_p >= limit);
    lc_a   = p_soft ? 8'd0 : lc_p;
    // then the new byte
    n_en   = !blank || end_of_message;
    n_esc  = blank || qpe_pkg::needs_escape(data_byte);
    if (blank) begin
      lc_n = lc_a;
    end else if (qpe_pkg::is_eol(data_byte)) begin
      lc_n = 8'd0;
    end else begin
      lc_n = qpe_pkg::count_add(lc_a, n_esc ? 2'd3 : 2'd1);
    end
    n_soft = !blank && cfg.soft_breaks && (lc_n >= limit);

    push_data.mask   = {n_soft, n_en, p_soft, pend_valid};
    push_data.p_esc  = p_esc;
    push_data.p_byte = pend_byte;
    push_data.n_esc  = n_esc;
    push_data.n_byte = data_byte;
    push_valid       = in_valid && (push_data.mask != 4'd0);

    pend_valid_next = blank && !end_of_message;
    pend_byte_next  = pend_valid_next ? data_byte : pend_byte;
    line_count_next = end_of_message ? 8'd0 : (n_soft ? 8'd0 : lc_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      line_count <= 8'd0;
    end else if (accept) begin
      pend_valid <= pend_valid_next;
      line_count <= line_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_byte <= pend_byte_next;
    end
  end

endmodule

// File: src/qpe_queue.sv
// qpe_queue: small descriptor queue between front and back.
// Depends on qpe_pkg.
`timescale 1ns / 1ps

module qpe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  qpe_pkg::desc_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output qpe_pkg::desc_t pop_data
);

  qpe_pkg::desc_t mem [qpe_pkg::QDepth];
  logic [qpe_pkg::QAw-1:0] wr_ptr, rd_ptr;
  logic [qpe_pkg::QCw-1:0] count;
  logic push, pop;

  assign push_ready = (count != qpe_pkg::QCw'(qpe_pkg::QDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // occupancy follows the pointers
  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count != qpe_pkg::QCw'(qpe_pkg::QDepth)) |->
      (count[qpe_pkg::QAw-1:0] == qpe_pkg::QAw'(wr_ptr - rd_ptr)))
    else $error("queue count disagrees with pointers");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

// File: src/qpe_back.sv
// qpe_back: expands queued descriptors into output bytes, one per cycle
// while the receiver is ready, through a registered output stage. Depends on qpe_pkg.
`timescale 1ns / 1ps

module qpe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  qpe_pkg::desc_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);

  logic           cur_valid;
  qpe_pkg::desc_t cur;
  qpe_pkg::unit_t unit;
  logic [1:0]     sub;

  logic           emit, load, multi, unit_last, more, run_end;
  logic [3:0]     allow;
  qpe_pkg::unit_t unit_next;
  logic [7:0]     lit, ch;
  logic           esc;

  assign emit = cur_valid && (!out_valid || out_ready);

  always_comb begin
    allow     = 4'b1110 << unit;
    more      = |(cur.mask & allow);
    unit_next = qpe_pkg::pick_unit(cur.mask, allow);
    lit       = (unit == qpe_pkg::UNIT_NEW) ? cur.n_byte : cur.p_byte;
    esc       = (unit == qpe_pkg::UNIT_NEW) ? cur.n_esc : cur.p_esc;
    ch        = qpe_pkg::ChEq;
    case (unit)
      qpe_pkg::UNIT_PEND, qpe_pkg::UNIT_NEW: begin
        multi = esc;
        case (sub)
          2'd0:    ch = esc ? qpe_pkg::ChEq : lit;
          2'd1:    ch = qpe_pkg::hex_char(lit[7:4]);
          2'd2:    ch = qpe_pkg::hex_char(lit[3:0]);
          default: ch = qpe_pkg::ChEq;
        endcase
      end
      default: begin
        // soft break: = CR LF
        multi = 1'b1;
        case (sub)
          2'd1:    ch = qpe_pkg::ChCr;
          2'd2:    ch = qpe_pkg::ChLf;
          default: ch = qpe_pkg::ChEq;
        endcase
      end
    endcase
    unit_last = !multi || (sub == 2'd2);
    run_end   = unit_last && !more;
    load      = pop_valid && (!cur_valid || (emit && run_end));
  end

  assign pop_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
    end else if (emit && run_end) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= pop_data;
      unit <= qpe_pkg::pick_unit(pop_data.mask, 4'b1111);
      sub  <= 2'd0;
    end else if (emit) begin
      if (unit_last) begin
        unit <= unit_next;
        sub  <= 2'd0;
      end else begin
        sub <= sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= ch;
      last_of_run <= run_end;
    end
  end

  a_unit_present: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.mask[unit])
    else $error("walking a unit absent from the descriptor");

  a_literal_single: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !multi) |-> (sub == 2'd0))
    else $error("literal unit past its first byte");

endmodule

// File: src/quoted_printable_encoder.sv
// quoted_printable_encoder: top level, configuration registers and the
// front / queue / back chain. Depends on qpe_pkg, qpe_stream_if and submodules.
`timescale 1ns / 1ps

// usage
//   msg carries one raw message byte per request plus an end-of-message
//   flag; enc carries encoded bytes, last_of_run marking the final byte
//   caused by a request. a space or tab not at message end is held and
//   makes no output bytes until the next request.
//   registers: add_soft_breaks at byte address 0, line_limit at 4, written
//   through the apb port while the block is idle; pready is tied high.
// pipeline and output
//   the front classifies a request in the cycle it is accepted and pushes a
//   descriptor into a 4-deep queue; the back loads it into its descriptor
//   register and emits from there through the registered output stage.
//   the back emits one byte per cycle while the receiver is ready; a request
//   makes 0 to 10 bytes: 1 for a plain byte, 3 for an escape, plus 3 per
//   soft break. the output serializer sets the rate.
// reset and stall
//   rst (synchronous) clears the held blank, line count, queue and output
//   stage, and restores soft breaks off and line limit 72.
//   a stalled receiver holds the output register; the back stops, the queue
//   fills and msg.ready drops only when the queue is full.

module quoted_printable_encoder (
  input  logic                        clk,
  input  logic                        rst,
  qpe_msg_if.sink                     msg,
  qpe_enc_if.source                   enc,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qpe_pkg::PAddrW-1:0]  paddr,
  input  logic [qpe_pkg::PDataW-1:0]  pwdata,
  output logic [qpe_pkg::PDataW-1:0]  prdata,
  output logic                        pready
);

  qpe_pkg::cfg_t  cfg;
  qpe_pkg::desc_t push_data, pop_data;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  logic           cfg_write;

  // apb register file: index is the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.soft_breaks <= 1'b0;
      cfg.line_limit  <= qpe_pkg::LimitReset;
    end else if (cfg_write) begin
      if (paddr[2] == qpe_pkg::RegSoftBreaks) begin
        cfg.soft_breaks <= pwdata[0];
      end else begin
        cfg.line_limit <= pwdata[6:0];
      end
    end
  end

  // read back whichever register the address selects
  assign prdata = (paddr[2] == qpe_pkg::RegLineLimit)
                ? {{(qpe_pkg::PDataW-7){1'b0}}, cfg.line_limit}
                : {{(qpe_pkg::PDataW-1){1'b0}}, cfg.soft_breaks};

  // front: classify each request and track held blank and line count
  qpe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (msg.valid),
    .in_ready       (msg.ready),
    .data_byte      (msg.data_byte),
    .end_of_message (msg.end_of_message),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  // decoupling queue so input keeps flowing while the output serializes
  qpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: one encoded byte per cycle into the output register while the receiver is ready
  qpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (enc.valid),
    .out_ready   (enc.ready),
    .out_byte    (enc.out_byte),
    .last_of_run (enc.last_of_run)
  );

endmodule

// File: tb/sv/tb_quoted_printable_encoder.sv
// tb_quoted_printable_encoder: self-checking bench for the quoted-printable encoder
// depends on qpe_pkg, qpe_msg_if / qpe_enc_if and the quoted_printable_encoder rtl
`timescale 1ns / 1ps

module tb_quoted_printable_encoder;
  import qpe_pkg::*;

  // run limits and pacing
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 16;   // margin for the output pipeline plus a full descriptor queue
  localparam int LongHold    = 200;  // receiver hold-off that backs the queue up

  // register map: one 32-bit register per 4 bytes
  localparam logic [PAddrW-1:0] AddrSoftBreaks = {RegSoftBreaks, 2'b00};
  localparam logic [PAddrW-1:0] AddrLineLimit  = {RegLineLimit, 2'b00};

  localparam logic [127:0] HexDigits = "0123456789ABCDEF";

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } enc_item_t;

  // directed stimulus row; typed rows carry up to four expected bytes, msb first
  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic        typed_en;
    logic [2:0]  n_typed;
    logic [31:0] typed;
  } dir_row_t;

  typedef enum logic [1:0] {
    MODE_MIX,        // short messages, every byte class
    MODE_LONG_LINE,  // long messages without hard line breaks
    MODE_SATURATE    // escapes only, no end of message: drives the line count to its ceiling
  } stim_mode_t;

  typedef struct packed {
    logic       soft_en;
    logic [6:0] limit;
    logic [8:0] items;
    stim_mode_t mode;
    logic       steady;  // no gaps on either side
    logic       hold;    // one long receiver hold-off at the start of the phase
  } phase_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic pready;

  qpe_msg_if msg_if ();
  qpe_enc_if enc_if ();

  quoted_printable_encoder DUT (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_if),
    .enc     (enc_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // encoder shadow: configuration and state
  logic       soft_breaks_cfg;
  logic [6:0] line_limit_cfg;
  logic       blank_held;
  logic [7:0] held_byte;
  logic [7:0] line_cnt;

  enc_item_t expected_q[$];
  int errors;
  int cycles;
  logic steady;
  logic hold_off_req;

  dir_row_t dir_rows [25];
  phase_t phases [7];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit: a hang or a lost output ends here
  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void flag_mismatch(input string what);
    errors++;
    if (errors <= 10) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void put_escaped(input logic [7:0] b, ref enc_item_t res[$]);
    res.insert(res.size(), enc_item_t'{ChEq, 1'b0});
    res.insert(res.size(), enc_item_t'{HexDigits[8*(15-b[7:4]) +: 8], 1'b0});
    res.insert(res.size(), enc_item_t'{HexDigits[8*(15-b[3:0]) +: 8], 1'b0});
  endfunction

  // line count saturates at 255
  function automatic void advance_count(input int k);
    int sum;
    sum = int'(line_cnt) + k;
    line_cnt = (sum > 255) ? 8'd255 : 8'(sum);
  endfunction

  // "=" CR LF once the count reaches the limit; a limit of 0 always fires
  function automatic void soft_break(ref enc_item_t res[$]);
    if (soft_breaks_cfg && line_cnt >= {1'b0, line_limit_cfg}) begin
      res.insert(res.size(), enc_item_t'{ChEq, 1'b0});
      res.insert(res.size(), enc_item_t'{ChCr, 1'b0});
      res.insert(res.size(), enc_item_t'{ChLf, 1'b0});
      line_cnt = 8'd0;
    end
  endfunction

  // bytes caused by one accepted request, last one marked
  function automatic void encode_request(input logic [7:0] b, input logic eom,
                                         ref enc_item_t res[$]);
    logic eol;
    logic blank;
    eol   = (b == ChCr) || (b == ChLf);
    blank = (b == ChSp) || (b == ChTab);

    // a held blank goes out first: escaped before a hard break, literal otherwise
    if (blank_held) begin
      if (eol) begin
        put_escaped(held_byte, res);
        advance_count(3);
      end else begin
        res.insert(res.size(), enc_item_t'{held_byte, 1'b0});
        advance_count(1);
      end
      blank_held = 1'b0;
      soft_break(res);
    end

    if (blank) begin
      // trailing blank at message end is escaped, uncounted, no soft break
      if (eom) begin
        put_escaped(b, res);
      end else begin
        held_byte  = b;
        blank_held = 1'b1;
      end
    end else begin
      if (eol) begin
        res.insert(res.size(), enc_item_t'{b, 1'b0});
        line_cnt = 8'd0;
      end else if (b < ChSp || b == ChEq || b > ChMax) begin
        put_escaped(b, res);
        advance_count(3);
      end else begin
        res.insert(res.size(), enc_item_t'{b, 1'b0});
        advance_count(1);
      end
      soft_break(res);
    end

    // end of message clears the hold and the count, the held byte is kept
    if (eom) begin
      blank_held = 1'b0;
      line_cnt   = 8'd0;
    end

    if (res.size() > 0) begin
      res[res.size()-1].last_of_run = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 7) ? int'($urandom_range(1, 3)) : int'($urandom_range(8, 30));
  endfunction

  function automatic logic [7:0] pick_byte(input stim_mode_t mode);
    logic [7:0] b;
    int r;
    if (mode == MODE_SATURATE) begin
      // only bytes that escape to three characters
      case ($urandom_range(0, 2))
        0: b = ChEq;
        1: b = 8'($urandom_range(127, 255));
        default: begin
          do b = 8'($urandom_range(0, 31));
          while (b == ChTab || b == ChCr || b == ChLf);
        end
      endcase
    end else begin
      do begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          b = 8'($urandom_range(33, 126));
        end else if (r < 60) begin
          b = $urandom_range(0, 1) ? ChSp : ChTab;
        end else if (r < 70) begin
          b = $urandom_range(0, 1) ? ChCr : ChLf;
        end else if (r < 85) begin
          b = 8'($urandom_range(0, 31));
        end else begin
          b = 8'($urandom_range(127, 255));
        end
      end while (mode == MODE_LONG_LINE && (b == ChCr || b == ChLf));
    end
    return b;
  endfunction

  // apb write: setup cycle, then access cycle; pready is sampled at the edge
  task automatic write_reg(input logic [PAddrW-1:0] addr, input logic [PDataW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AddrSoftBreaks) begin
      soft_breaks_cfg = data[0];
    end else if (addr == AddrLineLimit) begin
      line_limit_cfg = data[6:0];
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // offer one request, wait for it to be taken, then queue its expected bytes;
  // typed rows supply their own expectation, the shadow state still advances
  task automatic send_request(input logic [7:0] b, input logic eom, input logic typed_en,
                              input logic [2:0] n_typed, input logic [31:0] typed);
    enc_item_t batch[$];
    int gap;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      msg_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_if.valid          = 1'b1;
    msg_if.data_byte      = b;
    msg_if.end_of_message = eom;
    do @(posedge clk); while (!msg_if.ready);
    encode_request(b, eom, batch);
    if (typed_en) begin
      for (int k = 0; k < n_typed; k++) begin
        expected_q.insert(expected_q.size(),
                          enc_item_t'{typed[31-8*k -: 8], k == n_typed - 1});
      end
    end else begin
      expected_q = {expected_q, batch};
    end
    @(negedge clk);
  endtask

  // input idle, every expected byte seen, then a margin for requests that make no bytes
  task automatic drain_outputs();
    msg_if.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : enc_receiver
    int stall_left;
    stall_left   = 0;
    enc_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left == 0) begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          stall_left   = LongHold;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        enc_if.ready = 1'b0;
        stall_left--;
      end else begin
        enc_if.ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  // compare each accepted output byte with the oldest expectation
  always @(posedge clk) begin : enc_check
    enc_item_t want;
    if (!rst && enc_if.valid && enc_if.ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h last_of_run %b",
                                enc_if.out_byte, enc_if.last_of_run));
      end else begin
        want = expected_q.pop_front();
        if (enc_if.out_byte !== want.out_byte) begin
          flag_mismatch($sformatf("out_byte expected %h got %h",
                                  want.out_byte, enc_if.out_byte));
        end
        if (enc_if.last_of_run !== want.last_of_run) begin
          flag_mismatch($sformatf("last_of_run expected %b got %b (byte %h)",
                                  want.last_of_run, enc_if.last_of_run, want.out_byte));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    logic [7:0] b;
    logic eom;

    // everything known from time zero
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = 8'd0;
    msg_if.end_of_message = 1'b0;
    errors                = 0;
    steady                = 1'b0;
    hold_off_req          = 1'b0;

    // shadow state after reset: soft breaks off, limit 72, nothing held
    soft_breaks_cfg = 1'b0;
    line_limit_cfg  = LimitReset;
    blank_held      = 1'b0;
    held_byte       = 8'd0;
    line_cnt        = 8'd0;

    // directed part, reset configuration: soft breaks are off, so the count never shows
    dir_rows = '{
      '{8'h41, 1'b0, 1'b1, 3'd1, {"A", 24'h0}},        // plain byte
      '{8'h00, 1'b0, 1'b1, 3'd3, {"=00", 8'h0}},       // lowest control byte
      '{8'hFF, 1'b0, 1'b1, 3'd3, {"=FF", 8'h0}},       // highest byte
      '{ChEq,  1'b0, 1'b1, 3'd3, {"=3D", 8'h0}},       // equals sign always escaped
      '{8'h7E, 1'b0, 1'b1, 3'd1, {"~", 24'h0}},        // last literal byte
      '{8'h7F, 1'b0, 1'b1, 3'd3, {"=7F", 8'h0}},       // first byte above the literal range
      '{8'h1F, 1'b0, 1'b1, 3'd3, {"=1F", 8'h0}},       // last control byte
      '{ChSp,  1'b0, 1'b1, 3'd0, 32'h0},               // held space, no output
      '{8'h62, 1'b0, 1'b1, 3'd2, {" b", 16'h0}},       // held space goes out literally
      '{ChTab, 1'b0, 1'b1, 3'd0, 32'h0},               // held tab
      '{ChCr,  1'b0, 1'b1, 3'd4, {"=09", ChCr}},       // blank before cr is escaped
      '{ChLf,  1'b0, 1'b1, 3'd1, {ChLf, 24'h0}},       // lf passes through
      '{ChSp,  1'b1, 1'b1, 3'd3, {"=20", 8'h0}},       // blank at message end
      '{ChTab, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ChSp,  1'b0, 1'b1, 3'd1, {ChTab, 24'h0}},      // blank after blank: first literal
      '{8'h78, 1'b1, 1'b1, 3'd2, {" x", 16'h0}},
      '{ChSp,  1'b0, 1'b1, 3'd0, 32'h0},
      '{ChLf,  1'b0, 1'b1, 3'd4, {"=20", ChLf}},       // blank before lf is escaped
      '{ChTab, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ChTab, 1'b1, 1'b1, 3'd4, {ChTab, "=09"}},      // held tab, then tab at message end
      '{8'h80, 1'b1, 1'b1, 3'd3, {"=80", 8'h0}},
      '{ChCr,  1'b1, 1'b1, 3'd1, {ChCr, 24'h0}},
      '{8'h5A, 1'b0, 1'b0, 3'd0, 32'h0},
      '{ChSp,  1'b0, 1'b1, 3'd0, 32'h0},
      '{ChEq,  1'b1, 1'b1, 3'd4, " =3D"}               // held space, then escaped byte
    };

    // random phases: soft break extremes, an out-of-range limit of 0, count saturation
    phases = '{
      '{1'b1, 7'd1,   9'd50, MODE_MIX,       1'b0, 1'b0},
      '{1'b1, 7'd127, 9'd50, MODE_LONG_LINE, 1'b0, 1'b0},
      '{1'b1, 7'd2,   9'd50, MODE_MIX,       1'b1, 1'b0},
      '{1'b1, 7'd0,   9'd30, MODE_MIX,       1'b0, 1'b0},
      '{1'b0, 7'd72,  9'd90, MODE_SATURATE,  1'b0, 1'b0},
      // count sits at 255 from the phase before: the first counted byte breaks the line
      '{1'b1, 7'd127, 9'd40, MODE_MIX,       1'b1, 1'b1},
      '{1'b1, 7'd30,  9'd40, MODE_MIX,       1'b0, 1'b0}
    };
    phases[2].limit = 7'($urandom_range(2, 20));
    phases[6].limit = 7'($urandom_range(30, 90));

    // reset, released at a falling edge
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].data, dir_rows[i].eom, dir_rows[i].typed_en,
                   dir_rows[i].n_typed, dir_rows[i].typed);
    end

    foreach (phases[p]) begin
      // registers change only while the block is idle
      drain_outputs();
      write_reg(AddrSoftBreaks, PDataW'(phases[p].soft_en));
      write_reg(AddrLineLimit, PDataW'(phases[p].limit));
      steady       = phases[p].steady;
      hold_off_req = phases[p].hold;
      repeat (phases[p].items) begin
        b = pick_byte(phases[p].mode);
        case (phases[p].mode)
          MODE_MIX:       eom = ($urandom_range(0, 9) == 0);
          MODE_LONG_LINE: eom = ($urandom_range(0, 99) == 0);
          default:        eom = 1'b0;
        endcase
        send_request(b, eom, 1'b0, 3'd0, 32'd0);
      end
    end

    // wait out the last bytes, then a margin for anything stray
    drain_outputs();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
